FILE: rtl/odf_pkg.sv
package odf_pkg;

    localparam int ODF_DEPTH = 64;
    localparam int KEY_W     = 31;
    localparam int PAYLOAD_W = 64;
    localparam int DEST_W    = 6;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic                 valid;
        logic [DEST_W-1:0]    dest;
    } t_rec;

    // datapath actions
    typedef logic [3:0] t_act;
    localparam t_act A_NONE      = 4'd0;
    localparam t_act A_LOAD      = 4'd1;
    localparam t_act A_STEP_ONE  = 4'd2;
    localparam t_act A_STEP_GROW = 4'd3;
    localparam t_act A_I_TOP     = 4'd4;
    localparam t_act A_READ      = 4'd5;
    localparam t_act A_WR_LO     = 4'd6;
    localparam t_act A_WR_HI     = 4'd7;
    localparam t_act A_I_DEC     = 4'd8;
    localparam t_act A_STEP_HALF = 4'd9;
    localparam t_act A_I_ZERO    = 4'd10;
    localparam t_act A_EMIT      = 4'd11;
    localparam t_act A_CLEAR     = 4'd12;

    // wait conditions: the step holds until met
    typedef logic [1:0] t_wait;
    localparam t_wait W_NONE = 2'd0;
    localparam t_wait W_IN   = 2'd1;
    localparam t_wait W_OUT  = 2'd2;

    // jump conditions
    typedef logic [3:0] t_cond;
    localparam t_cond C_NEVER        = 4'd0;
    localparam t_cond C_ALWAYS       = 4'd1;
    localparam t_cond C_NOT_LAST     = 4'd2;
    localparam t_cond C_N_SMALL      = 4'd3;
    localparam t_cond C_GROW         = 4'd4;
    localparam t_cond C_OUT_RANGE    = 4'd5;
    localparam t_cond C_NO_SWAP      = 4'd6;
    localparam t_cond C_I_NONZERO    = 4'd7;
    localparam t_cond C_STEP_NOT_ONE = 4'd8;
    localparam t_cond C_NOT_END      = 4'd9;

    typedef logic [3:0] t_pc;
    localparam t_pc PC_LOAD    = 4'd0;
    localparam t_pc PC_STEP1   = 4'd1;
    localparam t_pc PC_GROW    = 4'd2;
    localparam t_pc PC_PASS    = 4'd3;
    localparam t_pc PC_READ    = 4'd4;
    localparam t_pc PC_CHECK   = 4'd5;
    localparam t_pc PC_WR_LO   = 4'd6;
    localparam t_pc PC_WR_HI   = 4'd7;
    localparam t_pc PC_NEXT    = 4'd8;
    localparam t_pc PC_HALVE   = 4'd9;
    localparam t_pc PC_EMIT0   = 4'd10;
    localparam t_pc PC_EMIT_RD = 4'd11;
    localparam t_pc PC_EMIT    = 4'd12;
    localparam t_pc PC_FINISH  = 4'd13;

    typedef struct packed {
        t_act  act;
        t_wait wt;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic out_free;
        logic n_small;
        logic grow;
        logic out_range;
        logic no_swap;
        logic i_nonzero;
        logic step_not_one;
        logic not_end;
    } t_flags;

    typedef struct packed {
        t_act act;
        logic fire;
    } t_ctl;

    // microprogram: on a true condition jump to target, else fall through
    function automatic t_uword odf_rom(input t_pc pc);
        unique case (pc)
            PC_LOAD:    odf_rom = '{act: A_LOAD,      wt: W_IN,   cond: C_NOT_LAST,
                                    target: PC_LOAD};
            PC_STEP1:   odf_rom = '{act: A_STEP_ONE,  wt: W_NONE, cond: C_N_SMALL,
                                    target: PC_EMIT0};
            PC_GROW:    odf_rom = '{act: A_STEP_GROW, wt: W_NONE, cond: C_GROW,
                                    target: PC_GROW};
            PC_PASS:    odf_rom = '{act: A_I_TOP,     wt: W_NONE, cond: C_NEVER,
                                    target: PC_LOAD};
            PC_READ:    odf_rom = '{act: A_READ,      wt: W_NONE, cond: C_OUT_RANGE,
                                    target: PC_NEXT};
            PC_CHECK:   odf_rom = '{act: A_NONE,      wt: W_NONE, cond: C_NO_SWAP,
                                    target: PC_NEXT};
            PC_WR_LO:   odf_rom = '{act: A_WR_LO,     wt: W_NONE, cond: C_NEVER,
                                    target: PC_LOAD};
            PC_WR_HI:   odf_rom = '{act: A_WR_HI,     wt: W_NONE, cond: C_NEVER,
                                    target: PC_LOAD};
            PC_NEXT:    odf_rom = '{act: A_I_DEC,     wt: W_NONE, cond: C_I_NONZERO,
                                    target: PC_READ};
            PC_HALVE:   odf_rom = '{act: A_STEP_HALF, wt: W_NONE, cond: C_STEP_NOT_ONE,
                                    target: PC_PASS};
            PC_EMIT0:   odf_rom = '{act: A_I_ZERO,    wt: W_NONE, cond: C_NEVER,
                                    target: PC_LOAD};
            PC_EMIT_RD: odf_rom = '{act: A_READ,      wt: W_NONE, cond: C_NEVER,
                                    target: PC_LOAD};
            PC_EMIT:    odf_rom = '{act: A_EMIT,      wt: W_OUT,  cond: C_NOT_END,
                                    target: PC_EMIT_RD};
            PC_FINISH:  odf_rom = '{act: A_CLEAR,     wt: W_NONE, cond: C_ALWAYS,
                                    target: PC_LOAD};
            default:    odf_rom = '{act: A_NONE,      wt: W_NONE, cond: C_ALWAYS,
                                    target: PC_LOAD};
        endcase
    endfunction

endpackage

FILE: rtl/odf_in_if.sv
interface odf_in_if import odf_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [KEY_W-1:0]     record_key;
    logic [PAYLOAD_W-1:0] record_payload;
    logic                 record_valid;
    logic [DEST_W-1:0]    dest_index;
    logic                 last_record;

    modport source (output valid, record_key, record_payload, record_valid, dest_index,
                    last_record, input ready);
    modport sink   (input valid, record_key, record_payload, record_valid, dest_index,
                    last_record, output ready);
endinterface

FILE: rtl/odf_out_if.sv
interface odf_out_if import odf_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [KEY_W-1:0]     out_key;
    logic [PAYLOAD_W-1:0] out_payload;
    logic                 out_valid;
    logic                 out_last;

    modport source (output valid, out_key, out_payload, out_valid, out_last, input ready);
    modport sink   (input valid, out_key, out_payload, out_valid, out_last, output ready);
endinterface

FILE: rtl/odf_seq.sv
module odf_seq import odf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctl   o_ctl
);

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword word;
    logic   wait_ok;
    logic   cond_true;

    assign word = odf_rom(r_pc);

    always_comb begin
        unique case (word.wt)
            W_IN:    wait_ok = i_flags.in_valid;
            W_OUT:   wait_ok = i_flags.out_free;
            default: wait_ok = 1'b1;
        endcase
    end

    always_comb begin
        unique case (word.cond)
            C_ALWAYS:       cond_true = 1'b1;
            C_NOT_LAST:     cond_true = !i_flags.in_last;
            C_N_SMALL:      cond_true = i_flags.n_small;
            C_GROW:         cond_true = i_flags.grow;
            C_OUT_RANGE:    cond_true = i_flags.out_range;
            C_NO_SWAP:      cond_true = i_flags.no_swap;
            C_I_NONZERO:    cond_true = i_flags.i_nonzero;
            C_STEP_NOT_ONE: cond_true = i_flags.step_not_one;
            C_NOT_END:      cond_true = i_flags.not_end;
            default:        cond_true = 1'b0;
        endcase
    end

    always_comb begin
        if (!wait_ok) begin
            n_pc = r_pc;
        end else if (cond_true) begin
            n_pc = word.target;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl.act  = word.act;
    assign o_ctl.fire = wait_ok;

endmodule

FILE: rtl/oblivious_distribute_and_fill_top.sv
// Collects records one per cycle until the request marked last (requests past DEPTH
// are dropped), then reorders the set in place by a distribution network: for each
// power-of-two step below the record count, largest first, positions are visited
// from high to low and a valid record moves up by the step when that does not pass
// its destination. Empty slots are then filled from the slot below as the set is
// streamed out, one request per stored slot, the final one flagged out_last.
// The first step is found by doubling from 1. At each position the pair is read and,
// when a swap is made, the single write port of the record store takes the two halves
// of the swap in turn, the lower slot first. Each emitted slot is read from the store
// and then held until the output is free. The next set may begin loading while the
// last result still waits.
module oblivious_distribute_and_fill_top import odf_pkg::*; #(
    parameter int DEPTH = ODF_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    odf_in_if.sink    i_in,
    odf_out_if.source o_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int NW = AW + 1;
    localparam int CW = (NW > DEST_W) ? NW : DEST_W;

    t_rec          r_mem [DEPTH];
    t_rec          r_rd_a;
    t_rec          r_rd_b;
    t_rec          r_prev;
    t_rec          r_out;
    logic          r_out_last;
    logic          r_out_valid;
    logic [NW-1:0] r_count;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_step;

    t_ctl          ctl;
    t_flags        flags;
    logic          fire_act;
    logic [NW-1:0] hi_sum;
    logic [AW-1:0] hi_addr;
    logic          at_end;
    logic          out_free;
    logic          store_room;
    t_rec          in_rec;
    t_rec          emit_rec;
    logic          we;
    logic [AW-1:0] waddr;
    t_rec          wdata;
    logic          rd_en;

    odf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctl   (ctl)
    );

    assign fire_act   = ctl.fire;
    assign hi_sum     = NW'(r_idx) + NW'(r_step);
    assign hi_addr    = hi_sum[AW-1:0];
    assign at_end     = (NW'(r_idx) + NW'(1)) == r_count;
    assign out_free   = !r_out_valid || o_out.ready;
    assign store_room = r_count < NW'(DEPTH);

    assign in_rec.key     = i_in.record_key;
    assign in_rec.payload = i_in.record_payload;
    assign in_rec.valid   = i_in.record_valid;
    assign in_rec.dest    = i_in.dest_index;

    // fill-down: an empty slot takes the slot below as already filled
    assign emit_rec = (r_idx == '0 || r_rd_a.valid) ? r_rd_a : r_prev;

    always_comb begin
        flags.in_valid     = i_in.valid;
        flags.in_last      = i_in.last_record;
        flags.out_free     = out_free;
        flags.n_small      = r_count <= NW'(1);
        flags.grow         = (NW'(r_step) << 1) < r_count;
        flags.out_range    = hi_sum >= r_count;
        flags.no_swap      = !r_rd_a.valid || (CW'(hi_sum) > CW'(r_rd_a.dest));
        flags.i_nonzero    = r_idx != '0;
        flags.step_not_one = r_step != AW'(1);
        flags.not_end      = !at_end;
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = r_rd_b;
        unique case (ctl.act)
            A_LOAD: begin
                we    = fire_act && store_room;
                waddr = r_count[AW-1:0];
                wdata = in_rec;
            end
            A_WR_LO: begin
                we = 1'b1;
            end
            A_WR_HI: begin
                we    = 1'b1;
                waddr = hi_addr;
                wdata = r_rd_a;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    assign rd_en = ctl.act == A_READ;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd_a <= r_mem[r_idx];
            r_rd_b <= r_mem[hi_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ctl.act == A_LOAD && fire_act && store_room) begin
                r_count <= r_count + NW'(1);
            end else if (ctl.act == A_CLEAR) begin
                r_count <= '0;
            end
            if (ctl.act == A_EMIT && fire_act) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (ctl.act)
            A_STEP_ONE: begin
                r_step <= AW'(1);
            end
            A_STEP_GROW: begin
                if (flags.grow) begin
                    r_step <= r_step << 1;
                end
            end
            A_STEP_HALF: begin
                r_step <= r_step >> 1;
            end
            A_I_TOP: begin
                r_idx <= AW'(r_count - NW'(1));
            end
            A_I_DEC: begin
                if (flags.i_nonzero) begin
                    r_idx <= r_idx - AW'(1);
                end
            end
            A_I_ZERO: begin
                r_idx <= '0;
            end
            A_EMIT: begin
                if (fire_act) begin
                    r_out      <= emit_rec;
                    r_prev     <= emit_rec;
                    r_out_last <= at_end;
                    r_idx      <= r_idx + AW'(1);
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    assign i_in.ready        = ctl.act == A_LOAD;
    assign o_out.valid       = r_out_valid;
    assign o_out.out_key     = r_out.key;
    assign o_out.out_payload = r_out.payload;
    assign o_out.out_valid   = r_out.valid;
    assign o_out.out_last    = r_out_last;

endmodule
